FILE: design/cbf_pkg.sv
// Package for the counting Bloom filter: sizes, register indexes, command codes
// and the queue entry type. No dependencies.
package cbf_pkg;
  localparam int unsigned Capacity   = 4096;
  localparam int unsigned IdxW       = $clog2(Capacity);
  localparam int unsigned MaxHashes  = 6;
  localparam logic [63:0] MurmurM    = 64'hc6a4a7935bd1e995;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned QDepth     = 2;

  localparam logic [CfgIdxW-1:0] RegNumHashes   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCounterBits = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSeed0       = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSeed5       = 3'd7;

  localparam logic CmdInsert = 1'b0;
  localparam logic CmdQuery  = 1'b1;

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic            last;   // final index of this transaction
    logic            none;   // transaction selects no counter
    logic            query;
  } job_t;
endpackage

FILE: design/cbf_front.sv
// Front end: accepts a transaction and computes its counter indexes one
// hash at a time with MurmurHash64A. Depends on cbf_pkg.
module cbf_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               command_i,
  input  logic [63:0]        key_i,
  input  logic [3:0]         key_len_i,
  input  logic [2:0]         num_hashes_i,
  input  logic [6*64-1:0]    seeds_i,
  output logic               busy_o,
  output logic               push_o,
  output cbf_pkg::job_t      job_o,
  input  logic               full_i
);
  import cbf_pkg::*;

  // Each multiply by the hash constant runs in SM0..SM2 on one 32x32
  // multiplier and then returns to ret_q.
  localparam logic [3:0] SIdle = 4'd0, SK1 = 4'd1, SK2 = 4'd2, SK3 = 4'd3,
                         SF1 = 4'd4, SF2 = 4'd5, SOut = 4'd6, SNone = 4'd7,
                         SM0 = 4'd8, SM1 = 4'd9, SM2 = 4'd10;

  logic [3:0]  st_q, st_d;
  logic [63:0] key_q, h_q, h_d, k_q, k_d;
  logic [3:0]  len_q;
  logic        qry_q;
  logic [2:0]  i_q, i_d, n_q;
  logic [2:0]  sidx;
  logic [63:0] seed, mask, hinit;
  logic [63:0] mx_q, mx_d, acc_q, acc_d, mprod;
  logic [31:0] mul_a, mul_b;
  logic [3:0]  ret_q, ret_d;
  logic        tok_q, tok_d;

  always_comb begin
    sidx = (i_q >= 3'(MaxHashes)) ? i_q - 3'(MaxHashes) : i_q;
    seed = seeds_i[sidx*64 +: 64];
    mask = (len_q >= 4'd8) ? '1 : ((64'd1 << {len_q[2:0], 3'b000}) - 64'd1);
    hinit = seed ^ (64'(len_q) * MurmurM);
    // Low 64 bits of x*M from xl*Ml, then xl*Mh and xh*Ml shifted up.
    mul_a = (st_q == SM2) ? mx_q[63:32] : mx_q[31:0];
    mul_b = (st_q == SM1) ? MurmurM[63:32] : MurmurM[31:0];
    mprod = 64'(mul_a) * 64'(mul_b);
  end

  assign busy_o = st_q != SIdle;

  always_comb begin
    st_d = st_q; h_d = h_q; k_d = k_q; i_d = i_q;
    mx_d = mx_q; acc_d = acc_q; ret_d = ret_q; tok_d = tok_q;
    push_o = 1'b0;
    job_o.idx = h_q[IdxW-1:0];
    job_o.last = (i_q + 3'd1) == n_q;
    job_o.none = 1'b0;
    job_o.query = qry_q;
    unique case (st_q)
      SIdle: ;
      SK1: begin
        h_d = hinit;
        if (len_q >= 4'd8) begin
          mx_d = key_q; tok_d = 1'b1; ret_d = SK2; st_d = SM0;
        end else if (len_q == 4'd0) begin
          st_d = SF1;
        end else begin
          mx_d = hinit ^ (key_q & mask); tok_d = 1'b0; ret_d = SF1; st_d = SM0;
        end
      end
      SK2: begin
        mx_d = k_q ^ (k_q >> 47); tok_d = 1'b1; ret_d = SK3; st_d = SM0;
      end
      SK3: begin
        mx_d = h_q ^ k_q; tok_d = 1'b0; ret_d = SF1; st_d = SM0;
      end
      SF1: begin
        mx_d = h_q ^ (h_q >> 47); tok_d = 1'b0; ret_d = SF2; st_d = SM0;
      end
      SF2: begin h_d = h_q ^ (h_q >> 47); st_d = SOut; end
      SM0: begin acc_d = mprod; st_d = SM1; end
      SM1: begin acc_d = acc_q + {mprod[31:0], 32'd0}; st_d = SM2; end
      SM2: begin
        if (tok_q) k_d = acc_q + {mprod[31:0], 32'd0};
        else h_d = acc_q + {mprod[31:0], 32'd0};
        st_d = ret_q;
      end
      SOut: begin
        if (!full_i) begin
          push_o = 1'b1;
          i_d = i_q + 3'd1;
          st_d = job_o.last ? SIdle : SK1;
        end
      end
      SNone: begin
        job_o.none = 1'b1; job_o.last = 1'b1;
        if (!full_i) begin push_o = 1'b1; st_d = SIdle; end
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; i_q <= '0; n_q <= '0;
    end else if (st_q == SIdle) begin
      if (start_i) begin
        st_q <= (num_hashes_i == 3'd0) ? SNone : SK1;
        i_q <= '0; n_q <= num_hashes_i;
      end
    end else begin
      st_q <= st_d; i_q <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == SIdle && start_i) begin
      key_q <= key_i; qry_q <= command_i;
      len_q <= (key_len_i > 4'd8) ? 4'd8 : key_len_i;
    end
    h_q <= h_d; k_q <= k_d;
    mx_q <= mx_d; acc_q <= acc_d; ret_q <= ret_d; tok_q <= tok_d;
  end
endmodule

FILE: design/cbf_queue.sv
// Short queue of counter indexes between the hash front end and the
// counter back end. Depends on cbf_pkg.
module cbf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cbf_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output cbf_pkg::job_t data_o
);
  import cbf_pkg::*;
  job_t        mem_q [QDepth];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;

  assign full_o  = cnt_q == 2'(QDepth);
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end
endmodule

FILE: design/cbf_back.sv
// Back end: reads the selected counters, finds the minimum and applies the
// conservative update. Owns the counter memory. Depends on cbf_pkg.
module cbf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  cbf_pkg::job_t job_i,
  output logic          pop_o,
  input  logic [3:0]    counter_bits_i,
  output logic          ready_o,
  output logic          done_o,
  output logic [7:0]    count_o
);
  import cbf_pkg::*;

  localparam logic [2:0] BClear = 3'd0, BGet = 3'd1, BRead = 3'd2,
                         BWrite = 3'd3, BDone = 3'd4;

  logic [7:0]      store_q [Capacity];
  logic [2:0]      st_q;
  logic [IdxW:0]   clr_q;
  logic [IdxW-1:0] idx_q [MaxHashes+1];
  logic [2:0]      n_q, p_q;
  logic [7:0]      min_q, rd_q, sat;
  logic            qry_q, none_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_wa;
  logic [7:0]      mem_wd;
  logic [2:0]      rd_p;

  assign sat = (counter_bits_i >= 4'd8) ? 8'hFF : 8'((9'd1 << counter_bits_i) - 9'd1);
  assign ready_o = st_q != BClear;
  assign pop_o = st_q == BGet && !empty_i;

  always_comb begin
    mem_we = 1'b0; mem_wa = idx_q[p_q]; mem_wd = min_q + 8'd1;
    if (st_q == BClear) begin
      mem_we = 1'b1; mem_wa = clr_q[IdxW-1:0]; mem_wd = '0;
    end else if (st_q == BWrite && rd_q == min_q) begin
      mem_we = 1'b1;
    end
  end

  // While writing index p the next index is read, so each index is reread after any
  // earlier write to the same counter except that of the index just before it.
  always_comb begin
    if (st_q == BWrite && p_q + 3'd1 != n_q) rd_p = p_q + 3'd1;
    else if (st_q == BRead && p_q != n_q) rd_p = p_q;
    else rd_p = '0;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) store_q[mem_wa] <= mem_wd;
    rd_q <= store_q[idx_q[rd_p]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BClear; clr_q <= '0; n_q <= '0; p_q <= '0;
      min_q <= 8'hFF; qry_q <= 1'b0; none_q <= 1'b0;
      done_o <= 1'b0; count_o <= '0;
      for (int k = 0; k <= MaxHashes; k++) idx_q[k] <= '0;
    end else begin
      done_o <= 1'b0;
      unique case (st_q)
        BClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (IdxW+1)'(Capacity - 1)) st_q <= BGet;
        end
        BGet: if (!empty_i) begin
          idx_q[n_q] <= job_i.idx; qry_q <= job_i.query; none_q <= job_i.none;
          if (job_i.none) begin
            st_q <= BDone;
          end else begin
            n_q <= n_q + 3'd1;
            if (job_i.last) begin st_q <= BRead; p_q <= '0; end
          end
        end
        // Pipelined reads: rd_q holds idx_q[p_q-1] while p_q advances.
        BRead: begin
          if (p_q != 3'd0 && rd_q < min_q) min_q <= rd_q;
          if (p_q == n_q) begin
            p_q <= '0;
            st_q <= (!qry_q && ((rd_q < min_q ? rd_q : min_q) < sat)) ? BWrite : BDone;
          end else p_q <= p_q + 3'd1;
        end
        BWrite: begin
          // rd_q here is the read of idx_q[p_q] issued last cycle.
          p_q <= p_q + 3'd1;
          if (p_q + 3'd1 == n_q) begin
            st_q <= BDone; min_q <= min_q + 8'd1;
          end
        end
        BDone: begin
          done_o <= 1'b1; count_o <= none_q ? 8'hFF : min_q;
          min_q <= 8'hFF; n_q <= '0; p_q <= '0; st_q <= BGet;
        end
        default: st_q <= BGet;
      endcase
    end
  end
endmodule

FILE: design/counting_bloom_filter_top.sv
// Counting Bloom filter with conservative update, 4096 counters of 8 bits.
// After reset the counters are cleared, during which busy is high. The
// hash unit computes the n hashes one at a time on one shared 32x32
// multiplier, building each 64-bit multiply from three partial products.
// A query or a saturated insert reads every index once; an insert that
// counts then rereads each index and writes those that hold the minimum.
// busy drops in the cycle after done_o. done_o is high for one cycle with
// the count on count_o, which holds it until the next result; the result
// cannot be held off. Depends on cbf_pkg, cbf_front, cbf_queue, cbf_back.
module counting_bloom_filter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        command_i,
  input  logic [63:0] key_i,
  input  logic [3:0]  key_len_i,
  output logic        done_o,
  output logic [7:0]  count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [cbf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import cbf_pkg::*;

  logic [2:0]      num_hashes_q;
  logic [3:0]      counter_bits_q;
  logic [6*64-1:0] seeds_q;
  logic            fbusy, push, full, pop, empty, bready;
  job_t            fjob, qjob;
  logic            inflight_q;

  assign cfg_ready_o = 1'b1;
  assign busy = fbusy || inflight_q || !bready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_hashes_q <= 3'd3; counter_bits_q <= 4'd4; inflight_q <= 1'b0;
      for (int k = 0; k < 6; k++) seeds_q[k*64 +: 64] <= 64'(k);
    end else begin
      if (start && !busy) inflight_q <= 1'b1;
      else if (done_o) inflight_q <= 1'b0;
      if (cfg_valid_i) begin
        unique case (cfg_index_i) inside
          RegNumHashes:   num_hashes_q <= cfg_data_i[2:0];
          RegCounterBits: counter_bits_q <= cfg_data_i[3:0];
          [RegSeed0:RegSeed5]:
            seeds_q[(cfg_index_i - RegSeed0)*64 +: 64] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  cbf_front u_front (.clk_i, .rst_ni, .start_i(start && !busy), .command_i,
    .key_i, .key_len_i, .num_hashes_i(num_hashes_q), .seeds_i(seeds_q),
    .busy_o(fbusy), .push_o(push), .job_o(fjob), .full_i(full));

  cbf_queue u_queue (.clk_i, .rst_ni, .push_i(push), .data_i(fjob),
    .full_o(full), .pop_i(pop), .empty_o(empty), .data_o(qjob));

  cbf_back u_back (.clk_i, .rst_ni, .empty_i(empty), .job_i(qjob), .pop_o(pop),
    .counter_bits_i(counter_bits_q), .ready_o(bready), .done_o, .count_o);
endmodule

FILE: tb/testbench.sv
// Self-checking testbench for counting_bloom_filter_top: drives insert and query
// transactions, predicts each count with a local counter table, and checks it.
// Depends on cbf_pkg and the counting Bloom filter RTL.
`timescale 1ns / 1ps

module testbench;
  import cbf_pkg::*;

  localparam logic [63:0] HashMul = 64'hc6a4a7935bd1e995;
  localparam int unsigned CycleLimit = 1500000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        command_i;
  logic [63:0] key_i;
  logic [3:0]  key_len_i;
  logic        done_o;
  logic [7:0]  count_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [63:0] cfg_data_i;

  counting_bloom_filter_top u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .command_i(command_i), .key_i(key_i), .key_len_i(key_len_i),
    .done_o(done_o), .count_o(count_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  // Local copy of the filter state and configuration.
  logic [2:0]  hash_count;
  logic [3:0]  width_bits;
  logic [63:0] seeds [6];
  logic [7:0]  counters [Capacity];

  logic [7:0]  count_queue [$];
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] murmur(logic [63:0] k, int unsigned len,
                                         logic [63:0] seed);
    logic [63:0] h;
    logic [63:0] kk;
    h = seed ^ (64'(len) * HashMul);
    if (len >= 8) begin
      kk = k * HashMul;
      kk = kk ^ (kk >> 47);
      kk = kk * HashMul;
      h = (h ^ kk) * HashMul;
    end else if (len > 0) begin
      h = (h ^ (k & ((64'd1 << (8 * len)) - 64'd1))) * HashMul;
    end
    h = h ^ (h >> 47);
    h = h * HashMul;
    h = h ^ (h >> 47);
    return h;
  endfunction

  function automatic logic [7:0] filter_count(logic cmd, logic [63:0] k,
                                              logic [3:0] len_in);
    int unsigned idx [8];
    int unsigned len;
    int unsigned bits;
    int unsigned sat;
    int unsigned minv;
    bit hit [8];
    len = (len_in > 8) ? 8 : len_in;
    bits = (width_bits > 8) ? 8 : width_bits;
    sat = (1 << bits) - 1;
    minv = 255;
    for (int i = 0; i < hash_count; i++) begin
      idx[i] = 32'(murmur(k, len, seeds[i % 6]) % Capacity);
      if (counters[idx[i]] < minv) minv = counters[idx[i]];
    end
    if (cmd == CmdInsert && minv < sat) begin
      for (int i = 0; i < hash_count; i++) hit[i] = counters[idx[i]] == minv;
      for (int i = 0; i < hash_count; i++) if (hit[i]) counters[idx[i]] = 8'(minv + 1);
      minv = minv + 1;
    end
    return 8'(minv);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (count_queue.size() == 0) begin
        $error("count: unexpected result, actual %0d", count_o);
        err_count++;
      end else begin
        if (count_o !== count_queue[0]) begin
          $error("count: expected %0d, actual %0d", count_queue[0], count_o);
          err_count++;
        end
        void'(count_queue.pop_front());
      end
    end
  end

  // start stays high after the accepting edge; the next gap or drain drops it.
  task automatic send_item(logic cmd, logic [63:0] k, logic [3:0] len);
    while ($urandom_range(99) < send_gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    command_i <= cmd;
    key_i <= k;
    key_len_i <= len;
    do @(posedge clk_i); while (busy);
    count_queue.push_back(filter_count(cmd, k, len));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (count_queue.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] index, logic [63:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (index)
      RegNumHashes:   hash_count = data[2:0];
      RegCounterBits: width_bits = data[3:0];
      default:        seeds[index - RegSeed0] = data;
    endcase
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_directed();
    send_item(CmdQuery, 64'd0, 4'd0);
    send_item(CmdInsert, 64'd0, 4'd0);
    send_item(CmdInsert, '1, 4'd8);
    send_item(CmdQuery, '1, 4'd8);
    send_item(CmdInsert, '1, 4'd15);   // long key acts as eight bytes
    send_item(CmdInsert, 64'h0123456789abcdef, 4'd3);
    send_item(CmdQuery, 64'h0123456789abcdef, 4'd3);
    for (int i = 0; i < 18; i++) send_item(CmdInsert, 64'h55, 4'd1); // saturate
    send_item(CmdQuery, 64'h55, 4'd1);
  endtask

  task automatic test_config_corners();
    write_reg(RegNumHashes, 64'd0);    // no hashes
    send_item(CmdInsert, 64'd7, 4'd2);
    send_item(CmdQuery, 64'd7, 4'd2);
    write_reg(RegNumHashes, 64'd7);    // seed selection wraps
    for (int s = 0; s < 6; s++) write_reg(RegSeed0 + 3'(s), s[0] ? '1 : 64'd0);
    send_item(CmdInsert, 64'hfeed, 4'd2);
    send_item(CmdQuery, 64'hfeed, 4'd2);
    write_reg(RegCounterBits, 64'd0);  // inserts never count
    send_item(CmdInsert, 64'hfeed, 4'd2);
    write_reg(RegCounterBits, 64'd15); // acts as eight bits
    for (int i = 0; i < 5; i++) send_item(CmdInsert, 64'hbeef, 4'd4);
    write_reg(RegCounterBits, 64'd1);  // width lowered below stored values
    send_item(CmdInsert, 64'hbeef, 4'd4);
    send_item(CmdQuery, 64'hbeef, 4'd4);
  endtask

  // Mostly repeated keys from a small pool so counters climb and collide.
  task automatic test_random(int unsigned n, int unsigned gap);
    logic [63:0] pool [16];
    int unsigned p;
    send_gap_pct = gap;
    for (int i = 0; i < 16; i++) pool[i] = rand64();
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(15);
      if ($urandom_range(9) < 7)
        send_item(1'($urandom_range(1)), pool[p], 4'($urandom_range(8)));
      else
        send_item(1'($urandom_range(1)), rand64(), 4'($urandom_range(15)));
      if (i == n / 2) drain();
    end
  endtask

  task automatic test_random_configs();
    write_reg(RegNumHashes, 64'd6);
    write_reg(RegCounterBits, 64'd8);
    for (int s = 0; s < 6; s++) write_reg(RegSeed0 + 3'(s), rand64());
    test_random(380, 14);
    write_reg(RegNumHashes, 64'd1);
    write_reg(RegCounterBits, 64'd2);
    test_random(380, 50);
    write_reg(RegNumHashes, 64'($urandom_range(1, 6)));
    write_reg(RegCounterBits, 64'($urandom_range(1, 8)));
    test_random(380, 0);
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    command_i = 1'b0;
    key_i = '0;
    key_len_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    send_gap_pct = 14;
    hash_count = 3'd3;
    width_bits = 4'd4;
    for (int s = 0; s < 6; s++) seeds[s] = 64'(s);
    for (int i = 0; i < Capacity; i++) counters[i] = 8'd0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_config_corners();
    test_random_configs();
    drain();
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

FILE: sim.f
design/cbf_pkg.sv
design/cbf_front.sv
design/cbf_queue.sv
design/cbf_back.sv
design/counting_bloom_filter_top.sv
tb/testbench.sv
